// ===== hw/rtl/tmh_pkg.sv =====
// shared constants, codes and types for the timer heap scheduler
`timescale 1ns / 1ps

package tmh_pkg;

	localparam int TIMER_SLOTS = 32;
	localparam int SLOT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam int CNT_W = $clog2(TIMER_SLOTS + 1);

	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TIMER_SLOTS - 1);
	localparam logic [SLOT_W:0] SLOT_COUNT = (SLOT_W + 1)'(TIMER_SLOTS);

	// command codes
	localparam logic [1:0] FUNC_CREATE = 2'd0;
	localparam logic [1:0] FUNC_CLEAR = 2'd1;
	localparam logic [1:0] FUNC_TICK = 2'd2;

	// result codes
	localparam logic [1:0] KIND_CREATED = 2'd0;
	localparam logic [1:0] KIND_FULL = 2'd1;
	localparam logic [1:0] KIND_CLEARED = 2'd2;
	localparam logic [1:0] KIND_FIRED = 2'd3;

	typedef struct packed {
		logic [31:0] id;
		logic [63:0] expiry;
		logic [31:0] period;
		logic periodic;
	} slot_rec_t;

	typedef struct packed {
		logic due;
		logic better;
		logic id_match;
	} alu_flags_t;

endpackage

// ===== hw/rtl/timer_heap_scheduler.sv =====
// timer queue top level: sequencer, valid bits, slot store and result register
//
//  channel  | signals                                      | direction
//  ---------+----------------------------------------------+----------
//  in       | in_valid, in_ready, func, interval,          | to block
//           | periodic, target_id                          |
//  out      | out_valid, out_ready, kind, tmr_id, last      | from block
//
// one command at a time; in_ready is high only while the sequencer is idle
// create: walks the valid bits for the lowest free slot
// clear: one slot store read per cycle through the shared compare unit
// tick: a pass to mark due timers, then a selection pass over the store per fired timer
// a full result register stalls the sequencer; no new command is taken while it waits
// reset clears valid bits and time count and sets the id counter to one; slot contents need no clearing
`timescale 1ns / 1ps

module timer_heap_scheduler (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [1:0] func,
	input  logic [31:0] interval,
	input  logic periodic,
	input  logic [31:0] target_id,
	output logic out_valid,
	input  logic out_ready,
	output logic [1:0] kind,
	output logic [31:0] tmr_id,
	output logic last
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CREATE = 3'd1;
	localparam logic [2:0] ST_CLEAR = 3'd2;
	localparam logic [2:0] ST_NOW = 3'd3;
	localparam logic [2:0] ST_MARK = 3'd4;
	localparam logic [2:0] ST_SELECT = 3'd5;
	localparam logic [2:0] ST_REPORT = 3'd6;
	localparam logic [2:0] ST_FIRE = 3'd7;

	logic [2:0] state_q;
	logic [tmh_pkg::SLOT_W:0] issue_q;
	logic chk_s1;
	logic [tmh_pkg::SLOT_W-1:0] idx_s1;
	logic [tmh_pkg::TIMER_SLOTS-1:0] slot_valid_q;
	logic [tmh_pkg::TIMER_SLOTS-1:0] due_q;
	logic [63:0] now_q;
	logic [31:0] id_ctr_q;
	logic [31:0] interval_q;
	logic periodic_q;
	logic [31:0] target_q;
	logic [tmh_pkg::CNT_W-1:0] remaining_q;
	tmh_pkg::slot_rec_t best_q;
	logic [tmh_pkg::SLOT_W-1:0] best_idx_q;
	logic have_best_q;
	logic [1:0] res_kind_q;
	logic [31:0] res_id_q;
	logic out_valid_q;
	logic [1:0] kind_q;
	logic [31:0] tmr_id_q;
	logic last_q;

	logic in_xfer;
	logic in_scan;
	logic out_free;
	logic scan_end;
	logic [tmh_pkg::SLOT_W-1:0] cur_idx;
	logic cr_free;
	logic mark_hit;
	logic sel_take;
	logic clr_hit;
	logic fire_go;
	logic [31:0] id_next;
	logic [31:0] addend;
	logic [63:0] sum;
	tmh_pkg::alu_flags_t flags;
	tmh_pkg::slot_rec_t rd_rec;
	tmh_pkg::slot_rec_t wr_rec;
	logic ram_we;
	logic [tmh_pkg::SLOT_W-1:0] ram_wa;

	assign in_ready = (state_q == ST_IDLE);
	assign in_xfer = in_valid && in_ready;
	assign in_scan = (state_q == ST_CLEAR) || (state_q == ST_MARK) || (state_q == ST_SELECT);
	assign out_free = !out_valid_q || out_ready;
	assign cur_idx = issue_q[tmh_pkg::SLOT_W-1:0];
	assign scan_end = chk_s1 && (idx_s1 == tmh_pkg::LAST_SLOT);
	assign cr_free = !slot_valid_q[cur_idx];
	assign mark_hit = chk_s1 && slot_valid_q[idx_s1] && flags.due;
	assign sel_take = chk_s1 && due_q[idx_s1] && (!have_best_q || flags.better);
	assign clr_hit = chk_s1 && slot_valid_q[idx_s1] && flags.id_match;
	assign fire_go = (state_q == ST_FIRE) && out_free;
	// ids skip zero on wrap
	assign id_next = (id_ctr_q == 32'hFFFF_FFFF) ? 32'd1 : id_ctr_q + 32'd1;

	always_comb begin
		unique case (state_q)
			ST_NOW: addend = 32'd1;
			ST_FIRE: addend = best_q.period;
			default: addend = interval_q;
		endcase
	end

	tmh_alu u_alu (
		.now(now_q),
		.addend(addend),
		.cand(rd_rec),
		.best_expiry(best_q.expiry),
		.best_id(best_q.id),
		.target(target_q),
		.sum(sum),
		.flags(flags)
	);

	always_comb begin
		ram_we = 1'b0;
		ram_wa = cur_idx;
		wr_rec.id = id_ctr_q;
		wr_rec.expiry = sum;
		wr_rec.period = interval_q;
		wr_rec.periodic = periodic_q;
		if (state_q == ST_CREATE) begin
			ram_we = cr_free;
		end else if (state_q == ST_FIRE) begin
			// re-arm a periodic timer with its stored record
			ram_we = fire_go && best_q.periodic;
			ram_wa = best_idx_q;
			wr_rec.id = best_q.id;
			wr_rec.period = best_q.period;
			wr_rec.periodic = 1'b1;
		end
	end

	tmh_ram #(
		.WIDTH($bits(tmh_pkg::slot_rec_t)),
		.DEPTH(tmh_pkg::TIMER_SLOTS)
	) u_store (
		.clk(clk),
		.we(ram_we),
		.wa(ram_wa),
		.wd(wr_rec),
		.ra(cur_idx),
		.rd(rd_rec)
	);

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			issue_q <= '0;
			chk_s1 <= 1'b0;
			slot_valid_q <= '0;
			due_q <= '0;
			now_q <= 64'd0;
			id_ctr_q <= 32'd1;
			remaining_q <= '0;
			have_best_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			chk_s1 <= in_scan && (issue_q != tmh_pkg::SLOT_COUNT);
			// a finished pass restarts the address for the next one
			if ((in_scan || state_q == ST_CREATE) && !scan_end) begin
				if (issue_q != tmh_pkg::SLOT_COUNT) begin
					issue_q <= issue_q + 1'b1;
				end
			end else begin
				issue_q <= '0;
			end

			if (fire_go || (state_q == ST_REPORT && out_free)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						unique case (func)
							tmh_pkg::FUNC_CREATE: state_q <= ST_CREATE;
							tmh_pkg::FUNC_CLEAR: state_q <= (target_id == 32'd0) ? ST_REPORT : ST_CLEAR;
							tmh_pkg::FUNC_TICK: state_q <= ST_NOW;
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_CREATE: begin
					if (cr_free) begin
						slot_valid_q[cur_idx] <= 1'b1;
						id_ctr_q <= id_next;
						state_q <= ST_REPORT;
					end else if (cur_idx == tmh_pkg::LAST_SLOT) begin
						state_q <= ST_REPORT;
					end
				end
				ST_CLEAR: begin
					if (clr_hit) begin
						slot_valid_q[idx_s1] <= 1'b0;
						state_q <= ST_REPORT;
					end else if (scan_end) begin
						state_q <= ST_REPORT;
					end
				end
				ST_NOW: begin
					now_q <= sum;
					remaining_q <= '0;
					state_q <= ST_MARK;
				end
				ST_MARK: begin
					if (chk_s1) begin
						due_q[idx_s1] <= mark_hit;
						if (mark_hit) begin
							remaining_q <= remaining_q + 1'b1;
						end
					end
					if (scan_end) begin
						have_best_q <= 1'b0;
						state_q <= (remaining_q == '0 && !mark_hit) ? ST_IDLE : ST_SELECT;
					end
				end
				ST_SELECT: begin
					if (sel_take) begin
						have_best_q <= 1'b1;
					end
					if (scan_end) begin
						state_q <= ST_FIRE;
					end
				end
				ST_REPORT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_FIRE: begin
					if (out_free) begin
						due_q[best_idx_q] <= 1'b0;
						if (!best_q.periodic) begin
							slot_valid_q[best_idx_q] <= 1'b0;
						end
						remaining_q <= remaining_q - 1'b1;
						have_best_q <= 1'b0;
						state_q <= (remaining_q == tmh_pkg::CNT_W'(1)) ? ST_IDLE : ST_SELECT;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		idx_s1 <= cur_idx;
		if (in_xfer) begin
			interval_q <= interval;
			periodic_q <= periodic;
			target_q <= target_id;
			res_kind_q <= tmh_pkg::KIND_CLEARED;
			res_id_q <= 32'd0;
		end
		if (state_q == ST_CREATE) begin
			if (cr_free) begin
				res_kind_q <= tmh_pkg::KIND_CREATED;
				res_id_q <= id_ctr_q;
			end else begin
				res_kind_q <= tmh_pkg::KIND_FULL;
				res_id_q <= 32'd0;
			end
		end
		if (state_q == ST_CLEAR && clr_hit) begin
			res_id_q <= target_q;
		end
		if (state_q == ST_SELECT && sel_take) begin
			best_q <= rd_rec;
			best_idx_q <= idx_s1;
		end
		if (state_q == ST_REPORT && out_free) begin
			kind_q <= res_kind_q;
			tmr_id_q <= res_id_q;
			last_q <= 1'b1;
		end else if (fire_go) begin
			kind_q <= tmh_pkg::KIND_FIRED;
			tmr_id_q <= best_q.id;
			last_q <= (remaining_q == tmh_pkg::CNT_W'(1));
		end
	end

	assign out_valid = out_valid_q;
	assign kind = kind_q;
	assign tmr_id = tmr_id_q;
	assign last = last_q;

endmodule

// ===== hw/rtl/tmh_ram.sv =====
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module tmh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic clk,
	input  logic we,
	input  logic [AW-1:0] wa,
	input  logic [WIDTH-1:0] wd,
	input  logic [AW-1:0] ra,
	output logic [WIDTH-1:0] rd
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_q <= mem[ra];
	end

	assign rd = rd_q;

endmodule

// ===== hw/rtl/tmh_alu.sv =====
// shared adder and compare unit used by every scan of the slot store
`timescale 1ns / 1ps

module tmh_alu (
	input  logic [63:0] now,
	input  logic [31:0] addend,
	input  tmh_pkg::slot_rec_t cand,
	input  logic [63:0] best_expiry,
	input  logic [31:0] best_id,
	input  logic [31:0] target,
	output logic [63:0] sum,
	output tmh_pkg::alu_flags_t flags
);

	// expiry sums wrap modulo 2^64
	assign sum = now + {32'd0, addend};

	always_comb begin
		flags.due = (cand.expiry <= now);
		flags.better = (cand.expiry < best_expiry) ||
			((cand.expiry == best_expiry) && (cand.id < best_id));
		flags.id_match = (cand.id == target);
	end

endmodule

// ===== hw/rtl/tmh_checker.sv =====
// port level checks for the timer queue, bound to the top level
`timescale 1ns / 1ps

module tmh_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_ready,
	input  logic [1:0] func,
	input  logic out_valid,
	input  logic out_ready,
	input  logic [1:0] kind,
	input  logic [31:0] tmr_id,
	input  logic last
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(tmr_id) && $stable(last))
		else $error("result changed while stalled");

	// a full report carries no id and ends the command
	a_full_res: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == tmh_pkg::KIND_FULL |-> tmr_id == 32'd0 && last)
		else $error("bad create failure result");

	// create and clear give a single result
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != tmh_pkg::KIND_FIRED |-> last)
		else $error("command result not marked last");

	// handed out ids are never zero
	a_id_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == tmh_pkg::KIND_CREATED |-> tmr_id != 32'd0)
		else $error("created timer has id zero");

	// a real command keeps the block busy for at least the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (func == tmh_pkg::FUNC_CREATE || func == tmh_pkg::FUNC_CLEAR ||
			func == tmh_pkg::FUNC_TICK) |=> !in_ready)
		else $error("input taken during a command");

endmodule

bind timer_heap_scheduler tmh_checker u_tmh_checker (.*);
